>>> sv/pirl_pkg.sv
// Shared constants, types and status codes of the positional insert/remove list.
`timescale 1ns / 1ps

package pirl_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 5;
	localparam int OCC_W    = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef logic signed [DATA_W-1:0] data_t;

	// Broadcast from the controller to every cell in the row.
	typedef struct packed {
		logic             shift_up;
		logic             shift_down;
		logic [CMP_W-1:0] pos;
		data_t            value;
	} cell_ctrl_t;

endpackage

>>> sv/pirl_in_if.sv
// Request channel: operation, position and value to insert.
`timescale 1ns / 1ps

interface pirl_in_if
	import pirl_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [POS_W-1:0] position;
	data_t            value;

	modport source(output valid, output mode, output position, output value, input ready);
	modport sink(input valid, input mode, input position, input value, output ready);
endinterface

>>> sv/pirl_out_if.sv
// Result channel: removed value, status and occupancy.
`timescale 1ns / 1ps

interface pirl_out_if
	import pirl_pkg::*;
();
	logic             valid;
	logic             ready;
	data_t            removed_value;
	logic [1:0]       status;
	logic [OCC_W-1:0] occupancy;

	modport source(output valid, output removed_value, output status, output occupancy,
		input ready);
	modport sink(input valid, input removed_value, input status, input occupancy,
		output ready);
endinterface

>>> sv/pirl_cell.sv
// One list slot: holds an entry and trades it with its neighbors on insert or remove.
`timescale 1ns / 1ps

module pirl_cell
	import pirl_pkg::*;
(
	input  logic             clk,
	input  logic [CMP_W-1:0] idx,
	input  cell_ctrl_t       ctrl,
	input  data_t            left,
	input  data_t            right,
	output data_t            data,
	output data_t            hit
);

	data_t data_q;
	logic  at_pos;
	logic  past_pos;

	assign at_pos   = (idx == ctrl.pos);
	assign past_pos = (idx > ctrl.pos);

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			// make room: later entries move up, the new value lands at the position
			if (past_pos) begin
				data_q <= left;
			end else if (at_pos) begin
				data_q <= ctrl.value;
			end
		end else if (ctrl.shift_down && (past_pos || at_pos)) begin
			data_q <= right;
		end
	end

	assign data = data_q;
	assign hit  = at_pos ? data_q : '0;

endmodule

>>> sv/positional_insert_remove_list.sv
// Positional insert/remove list built as a row of CAPACITY entry cells.
// Result: registered on the accepting edge, visible in the cycle after the request transaction.
// Throughput: one transaction per cycle while rsp.ready holds; every cell shifts locally in the same edge.
// Reset: element count and result valid clear asynchronously; entries stay undefined.
`timescale 1ns / 1ps

module positional_insert_remove_list
	import pirl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pirl_in_if.sink     req,
	pirl_out_if.source  rsp
);

	logic [CNT_W-1:0] count_q;
	logic             valid_q;
	data_t            removed_q;
	status_t          status_q;

	logic             accept;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	status_t          status_d;
	logic             op_ok;
	cell_ctrl_t       ctrl;
	data_t            removed_d;

	data_t            cell_data [CAPACITY];
	data_t            cell_hit  [CAPACITY];

	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign pos_ext   = CMP_W'(req.position);
	assign cnt_ext   = CMP_W'(count_q);

	always_comb begin
		if (!req.mode) begin
			if (count_q == CNT_W'(CAPACITY)) begin
				status_d = ST_FULL;
			end else if (pos_ext > cnt_ext) begin
				status_d = ST_BADPOS;
			end else begin
				status_d = ST_OK;
			end
		end else begin
			if (count_q == '0) begin
				status_d = ST_EMPTY;
			end else if (pos_ext >= cnt_ext) begin
				status_d = ST_BADPOS;
			end else begin
				status_d = ST_OK;
			end
		end
	end

	assign op_ok           = accept && (status_d == ST_OK);
	assign ctrl.shift_up   = op_ok && !req.mode;
	assign ctrl.shift_down = op_ok && req.mode;
	assign ctrl.pos        = pos_ext;
	assign ctrl.value      = req.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		data_t left_w;
		data_t right_w;

		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		pirl_cell u_cell (
			.clk   (clk),
			.idx   (CMP_W'(i)),
			.ctrl  (ctrl),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.hit   (cell_hit[i])
		);
	end

	// only the cell at the position drives a nonzero hit
	always_comb begin
		removed_d = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			removed_d = removed_d | cell_hit[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
			if (ctrl.shift_up) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.shift_down) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			removed_q <= ctrl.shift_down ? removed_d : '0;
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.removed_value = removed_q;
	assign rsp.status        = status_q;
	assign rsp.occupancy     = OCC_W'(count_q);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift_up |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("successful insert did not grow the count");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !op_ok |=> count_q == $past(count_q))
		else $error("failed operation changed the count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q != ST_OK |-> removed_q == '0)
		else $error("failed operation returned a nonzero removed value");
`endif

endmodule
